### hw/rtl/block_bitmap_allocator_assert.svh
// Assertion macros for the block bitmap allocator.
// Depends on nothing; the including module supplies clock and reset signals.
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BBA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bitmap allocator check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bitmap allocator check failed");

`endif

### hw/rtl/bba_pkg.sv
// Shared constants and codes for the block bitmap allocator.
// Depends on nothing; the top level uses it by scoped names.
package bba_pkg;

   localparam int SUBPARTS       = 4;
   localparam int UNITS_PER_PART = 65536;
   localparam int SECTOR_BITS    = 4096;
   localparam int WORD_BITS      = 32;

   localparam int TOTAL_UNITS      = SUBPARTS * UNITS_PER_PART;
   localparam int WORD_COUNT       = TOTAL_UNITS / WORD_BITS;
   localparam int WORDS_PER_PART   = UNITS_PER_PART / WORD_BITS;
   localparam int WORDS_PER_SECTOR = SECTOR_BITS / WORD_BITS;
   localparam int SECTORS_PER_PART = UNITS_PER_PART / SECTOR_BITS;

   localparam int ADDR_W      = $clog2(WORD_COUNT);
   localparam int PART_WORD_W = $clog2(WORDS_PER_PART);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int LIM_W       = $clog2(WORDS_PER_PART + 1);

   // Field widths fixed by the interface.
   localparam int SUBPART_W   = 2;
   localparam int INDEX_W     = 16;
   localparam int UCOUNT_W    = 17;
   localparam int USED_W      = 19;
   localparam int AMOUNT_W    = 26;
   localparam int CSR_DATA_W  = 19;
   localparam int SHIFT_W     = 3;
   localparam int SPCOUNT_W   = 3;

   typedef enum logic [1:0] {
      REQ_COUNT = 2'd0,
      REQ_ALLOC = 2'd1,
      REQ_FREE  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_INVALID  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_SUBPART_COUNT = 3'd0,
      CSR_UNIT_COUNT_0  = 3'd1,
      CSR_UNIT_COUNT_1  = 3'd2,
      CSR_UNIT_COUNT_2  = 3'd3,
      CSR_UNIT_COUNT_3  = 3'd4,
      CSR_RESERVED      = 3'd5,
      CSR_UNIT_SHIFT    = 3'd6
   } csr_index_type;

endpackage

### hw/rtl/block_bitmap_allocator.sv
// Top level of the block bitmap allocator: bitmap memory, scan sequencer, result register.
// Depends on bba_pkg and on the assertion macros in block_bitmap_allocator_assert.svh.
`include "block_bitmap_allocator_assert.svh"

// The allocator keeps one allocation bit per unit for up to four subpartitions in an
// internal 8192 x 32 bit memory and answers one request per beat: count the used units,
// allocate a named unit, allocate the first free unit of a subpartition, or free a unit.
// After reset the block sweeps the memory to zero, one word per cycle, and req_tready stays
// low until the sweep ends; configuration writes are taken during it as at any time.
// The block works on one request at a time. A count request or a rejected request has its
// result fields registered at the request beat and moved into the result register in
// ST_DONE once that register is free; a named allocate or a free first passes ST_RMW for
// its one memory read. A first-fit allocate streams the subpartition's bitmap words through
// the single memory read port, one word per cycle, and checks each one in a shared compare
// and lowest-zero-bit unit. A new request is taken as soon as the sequencer is idle again,
// even while the previous result beat still waits for rsp_tready. A running counter of set
// bits replaces a popcount scan, so a count request covers every subpartition at once.
module block_bitmap_allocator (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [1:0] subpart, [17:2] unit_index, [23:18] zero
   input  logic [1:0]  req_tuser,  // [1:0] req_type
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [1:0] status, [17:2] granted_index,
                                   // [18] already_free, [44:19] used_amount, [47:45] zero
   // Configuration write port.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [18:0] csr_wdata
);

   localparam int AW  = bba_pkg::ADDR_W;
   localparam int PW  = bba_pkg::PART_WORD_W;
   localparam int BW  = bba_pkg::BIT_W;
   localparam int LW  = bba_pkg::LIM_W;
   localparam int WB  = bba_pkg::WORD_BITS;
   localparam int SW  = bba_pkg::SUBPART_W;
   localparam int IW  = bba_pkg::INDEX_W;
   localparam int UW  = bba_pkg::USED_W;
   localparam int MW  = bba_pkg::AMOUNT_W;
   localparam int CW  = bba_pkg::UCOUNT_W;
   // Width of the sector count of the largest programmable unit count, rounded up.
   localparam int SEC_W = CW + 1 - $clog2(bba_pkg::SECTOR_BITS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Lowest clear bit of a bitmap word; only used on words that are not all ones.
   function automatic logic [BW-1:0] lowest_zero(input logic [WB-1:0] word);
      logic [BW-1:0] pos;
      pos = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (!word[i]) begin
            pos = BW'(i);
         end
      end
      return pos;
   endfunction

   // Configuration registers.
   logic [bba_pkg::SPCOUNT_W-1:0] subpart_count_ff;
   logic [CW-1:0]                 unit_count_ff [bba_pkg::SUBPARTS];
   logic [UW-1:0]                 reserved_ff;
   logic [bba_pkg::SHIFT_W-1:0]   unit_shift_ff;

   // Sequencer state.
   state_type      state_ff, state_in;
   logic [AW-1:0]  clr_ptr_ff, clr_ptr_in;
   logic [SW-1:0]  sp_ff, sp_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           is_free_ff, is_free_in;
   logic [LW-1:0]  lim_ff, lim_in;
   logic [LW-1:0]  chk_off_ff, chk_off_in;
   logic [LW-1:0]  scan_ptr_ff, scan_ptr_in;
   logic [UW-1:0]  used_ff, used_in;

   // Result being assembled, and the result beat register.
   logic [1:0]     res_status_ff, res_status_in;
   logic [IW-1:0]  res_granted_ff, res_granted_in;
   logic           res_free_ff, res_free_in;
   logic [MW-1:0]  res_amount_ff, res_amount_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [47:0]    rsp_data_ff, rsp_data_in;

   // Bitmap memory.
   logic [WB-1:0]  bitmap_mem [bba_pkg::WORD_COUNT];
   logic [WB-1:0]  rd_data_ff;
   logic [AW-1:0]  mem_raddr;
   logic [AW-1:0]  mem_waddr;
   logic [WB-1:0]  mem_wdata;
   logic           mem_we;

   // Request fields.
   logic [1:0]     in_type;
   logic [SW-1:0]  in_sp;
   logic [IW-1:0]  in_idx;
   logic           req_accept;

   // Shared helpers.
   logic           sp_bad;
   logic [CW:0]    uc_round;
   logic [SEC_W-1:0] sectors;
   logic [LW-1:0]  lim_calc;
   logic [UW-1:0]  net_used;
   logic [WB-1:0]  bit_mask;
   logic           bit_set;
   logic [BW-1:0]  zero_pos;

   assign in_type    = req_tuser;
   assign in_sp      = req_tdata[1:0];
   assign in_idx     = req_tdata[17:2];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A subpartition beyond the programmed count or beyond storage is rejected.
   assign sp_bad = ({1'b0, in_sp} >= subpart_count_ff) || (32'(in_sp) >= bba_pkg::SUBPARTS);

   // First-fit range in words: unit count rounded up to whole sectors, clamped to storage.
   assign uc_round = {1'b0, unit_count_ff[in_sp]} + (CW + 1)'(bba_pkg::SECTOR_BITS - 1);
   assign sectors  = SEC_W'(uc_round / bba_pkg::SECTOR_BITS);
   assign lim_calc = (32'(sectors) >= bba_pkg::SECTORS_PER_PART)
                   ? LW'(bba_pkg::WORDS_PER_PART)
                   : LW'(sectors) * LW'(bba_pkg::WORDS_PER_SECTOR);

   assign net_used = (used_ff > reserved_ff) ? (used_ff - reserved_ff) : '0;

   assign bit_mask = WB'(1) << idx_ff[BW-1:0];
   assign bit_set  = rd_data_ff[idx_ff[BW-1:0]];
   assign zero_pos = lowest_zero(rd_data_ff);

   always_comb begin
      state_in       = state_ff;
      clr_ptr_in     = clr_ptr_ff;
      sp_in          = sp_ff;
      idx_in         = idx_ff;
      is_free_in     = is_free_ff;
      lim_in         = lim_ff;
      chk_off_in     = chk_off_ff;
      scan_ptr_in    = scan_ptr_ff;
      used_in        = used_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      res_free_in    = res_free_ff;
      res_amount_in  = res_amount_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      mem_raddr      = {sp_ff, scan_ptr_ff[PW-1:0]};
      mem_waddr      = {sp_ff, chk_off_ff[PW-1:0]};
      mem_wdata      = rd_data_ff;
      mem_we         = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_ptr_ff;
            mem_wdata  = '0;
            clr_ptr_in = clr_ptr_ff + AW'(1);
            if (32'(clr_ptr_ff) == bba_pkg::WORD_COUNT - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               sp_in          = in_sp;
               idx_in         = in_idx;
               is_free_in     = (in_type == bba_pkg::REQ_FREE);
               res_status_in  = bba_pkg::STATUS_OK;
               res_granted_in = '0;
               res_free_in    = 1'b0;
               res_amount_in  = '0;
               state_in       = ST_DONE;
               unique case (in_type) inside
                  bba_pkg::REQ_COUNT: begin
                     res_amount_in = MW'({{(MW - UW){1'b0}}, net_used} << unit_shift_ff);
                  end
                  bba_pkg::REQ_ALLOC,
                  bba_pkg::REQ_FREE: begin
                     if (sp_bad) begin
                        res_status_in = bba_pkg::STATUS_INVALID;
                     end else if (in_type == bba_pkg::REQ_FREE || in_idx != '0) begin
                        mem_raddr = {in_sp, in_idx[IW-1:BW]};
                        state_in  = ST_RMW;
                     end else if (lim_calc == '0) begin
                        res_status_in = bba_pkg::STATUS_NO_SPACE;
                     end else begin
                        // Word 0 is read now; the scan keeps one read in flight.
                        mem_raddr   = {in_sp, PW'(0)};
                        lim_in      = lim_calc;
                        chk_off_in  = '0;
                        scan_ptr_in = LW'(1);
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     res_status_in = bba_pkg::STATUS_INVALID;
                  end
               endcase
            end
         end
         ST_RMW: begin
            mem_waddr = {sp_ff, idx_ff[IW-1:BW]};
            if (is_free_ff) begin
               if (bit_set) begin
                  mem_we    = 1'b1;
                  mem_wdata = rd_data_ff & ~bit_mask;
                  used_in   = used_ff - UW'(1);
               end else begin
                  res_free_in = 1'b1;
               end
            end else if (bit_set) begin
               res_status_in = bba_pkg::STATUS_NO_SPACE;
            end else begin
               mem_we         = 1'b1;
               mem_wdata      = rd_data_ff | bit_mask;
               used_in        = used_ff + UW'(1);
               res_granted_in = idx_ff;
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (rd_data_ff != {WB{1'b1}}) begin
               mem_we         = 1'b1;
               mem_wdata      = rd_data_ff | (WB'(1) << zero_pos);
               used_in        = used_ff + UW'(1);
               res_granted_in = {chk_off_ff[PW-1:0], zero_pos};
               state_in       = ST_DONE;
            end else if (chk_off_ff + LW'(1) == lim_ff) begin
               res_status_in = bba_pkg::STATUS_NO_SPACE;
               state_in      = ST_DONE;
            end else begin
               chk_off_in  = scan_ptr_ff;
               scan_ptr_in = scan_ptr_ff + LW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_amount_ff, res_free_ff, res_granted_ff,
                               res_status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Sequencer state and the result beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sp_ff          <= sp_in;
      idx_ff         <= idx_in;
      is_free_ff     <= is_free_in;
      lim_ff         <= lim_in;
      chk_off_ff     <= chk_off_in;
      scan_ptr_ff    <= scan_ptr_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      res_free_ff    <= res_free_in;
      res_amount_ff  <= res_amount_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Configuration registers; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         subpart_count_ff <= bba_pkg::SPCOUNT_W'(1);
         unit_count_ff[0] <= CW'(65536);
         unit_count_ff[1] <= '0;
         unit_count_ff[2] <= '0;
         unit_count_ff[3] <= '0;
         reserved_ff      <= '0;
         unit_shift_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bba_pkg::CSR_SUBPART_COUNT: subpart_count_ff <= csr_wdata[bba_pkg::SPCOUNT_W-1:0];
            bba_pkg::CSR_UNIT_COUNT_0:  unit_count_ff[0] <= csr_wdata[CW-1:0];
            bba_pkg::CSR_UNIT_COUNT_1:  unit_count_ff[1] <= csr_wdata[CW-1:0];
            bba_pkg::CSR_UNIT_COUNT_2:  unit_count_ff[2] <= csr_wdata[CW-1:0];
            bba_pkg::CSR_UNIT_COUNT_3:  unit_count_ff[3] <= csr_wdata[CW-1:0];
            bba_pkg::CSR_RESERVED:      reserved_ff      <= csr_wdata[UW-1:0];
            bba_pkg::CSR_UNIT_SHIFT:    unit_shift_ff    <= csr_wdata[bba_pkg::SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Bitmap memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= bitmap_mem[mem_raddr];
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
   end

   // A request beat always starts work that keeps the block busy for the next cycle.
   `BBA_ASSERT_NEXT(a_busy_after_accept, req_accept, !req_tready)
   // The scan never examines a word past the first-fit range.
   `BBA_ASSERT_NOW(a_scan_in_range, state_ff == ST_SCAN, chk_off_ff < lim_ff)
   // The set-bit counter never exceeds the storage size.
   `BBA_ASSERT_NOW(a_used_bound, 1'b1, 32'(used_ff) <= bba_pkg::TOTAL_UNITS)

endmodule

### tb/block_bitmap_allocator_checker.sv
// Scoreboard for the block bitmap allocator: predicts every result beat from the
// request beats and register writes it observes, then compares field by field.
// Depends on bba_pkg for sizes and codes; it drives no signal of the block.
`timescale 1ns / 1ps

module block_bitmap_allocator_checker
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [1:0] subpart, [17:2] unit_index, [23:18] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [1:0] status, [17:2] granted_index,
                                    // [18] already_free, [44:19] used_amount
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [18:0] csr_wdata,
   output int          outstanding,
   output int          mismatches
);

   typedef struct {
      status_type            status;
      logic [INDEX_W-1:0]    granted;
      logic                  already_free;
      logic [AMOUNT_W-1:0]   used_amount;
   } alloc_result_type;

   bit                    unit_map [0:TOTAL_UNITS-1];
   logic [USED_W-1:0]     used_total;
   logic [SPCOUNT_W-1:0]  subpart_count;
   logic [UCOUNT_W-1:0]   unit_counts [SUBPARTS];
   logic [USED_W-1:0]     reserved_units;
   logic [SHIFT_W-1:0]    unit_shift;
   alloc_result_type      awaited_results [$];
   int                    fail_total = 0;

   // Applies one request to the shadow bitmap and returns the result it should give.
   function automatic alloc_result_type resolve_request(input logic [1:0] kind,
                                                        input logic [1:0] sp,
                                                        input logic [15:0] idx);
      alloc_result_type r;
      int unsigned      base, limit, u, net;
      bit               found;
      r.status       = STATUS_OK;
      r.granted      = '0;
      r.already_free = 1'b0;
      r.used_amount  = '0;
      if (kind == REQ_COUNT) begin
         net = (used_total > reserved_units) ? used_total - reserved_units : 0;
         r.used_amount = AMOUNT_W'(net << unit_shift);
      end else if (!(kind == REQ_ALLOC || kind == REQ_FREE) || sp >= subpart_count) begin
         r.status = STATUS_INVALID;
      end else begin
         base = sp * UNITS_PER_PART;
         if (kind == REQ_FREE) begin
            if (unit_map[base + idx]) begin
               unit_map[base + idx] = 1'b0;
               used_total = used_total - 1'b1;
            end else begin
               r.already_free = 1'b1;
            end
         end else if (idx != 0) begin
            if (unit_map[base + idx]) begin
               r.status = STATUS_NO_SPACE;
            end else begin
               unit_map[base + idx] = 1'b1;
               used_total = used_total + 1'b1;
               r.granted = idx;
            end
         end else begin
            // First fit covers the unit count rounded up to whole sectors.
            limit = (unit_counts[sp] + SECTOR_BITS - 1) / SECTOR_BITS * SECTOR_BITS;
            if (limit > UNITS_PER_PART)
               limit = UNITS_PER_PART;
            found = 1'b0;
            u = 0;
            while (u < limit && !found) begin
               if (!unit_map[base + u]) begin
                  unit_map[base + u] = 1'b1;
                  used_total = used_total + 1'b1;
                  r.granted = INDEX_W'(u);
                  found = 1'b1;
               end else begin
                  u++;
               end
            end
            if (!found)
               r.status = STATUS_NO_SPACE;
         end
      end
      return r;
   endfunction

   task automatic compare_field(input string label, input int unsigned want,
                                input int unsigned seen);
      if (want != seen) begin
         fail_total++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, seen);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      alloc_result_type want;
      if (reset) begin
         unit_map       = '{default: 1'b0};
         used_total     = '0;
         subpart_count  = SPCOUNT_W'(1);
         unit_counts[0] = UCOUNT_W'(65536);
         unit_counts[1] = '0;
         unit_counts[2] = '0;
         unit_counts[3] = '0;
         reserved_units = '0;
         unit_shift     = '0;
         awaited_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SUBPART_COUNT: subpart_count     = csr_wdata[SPCOUNT_W-1:0];
               CSR_UNIT_COUNT_0:  unit_counts[0]    = csr_wdata[UCOUNT_W-1:0];
               CSR_UNIT_COUNT_1:  unit_counts[1]    = csr_wdata[UCOUNT_W-1:0];
               CSR_UNIT_COUNT_2:  unit_counts[2]    = csr_wdata[UCOUNT_W-1:0];
               CSR_UNIT_COUNT_3:  unit_counts[3]    = csr_wdata[UCOUNT_W-1:0];
               CSR_RESERVED:      reserved_units    = csr_wdata[USED_W-1:0];
               CSR_UNIT_SHIFT:    unit_shift        = csr_wdata[SHIFT_W-1:0];
               default: ;
            endcase
         end
         // A result beat at this edge belongs to a request taken at an earlier one,
         // so it is matched before this edge's request is predicted.
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               fail_total++;
               $display("%0t: result beat with no request waiting, actual tdata 0x%h",
                        $time, rsp_tdata);
            end else begin
               want = awaited_results.pop_front();
               compare_field("status", want.status, rsp_tdata[1:0]);
               compare_field("granted_index", want.granted, rsp_tdata[17:2]);
               compare_field("already_free", want.already_free, rsp_tdata[18]);
               compare_field("used_amount", want.used_amount, rsp_tdata[44:19]);
            end
         end
         if (req_tvalid && req_tready)
            awaited_results.push_back(resolve_request(req_tuser, req_tdata[1:0],
                                                      req_tdata[17:2]));
      end
      outstanding <= awaited_results.size();
      mismatches  <= fail_total;
   end

endmodule

### tb/block_bitmap_allocator_tb.sv
// Top of the allocator testbench: clock, reset, register programming, request stimulus
// and result back-pressure. Depends on bba_pkg, the block and block_bitmap_allocator_checker.
`timescale 1ns / 1ps

module block_bitmap_allocator_tb;
   import bba_pkg::*;

   // The block has no request type 3; it must answer it as invalid.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int CSR_COUNT     = 7;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 45;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 64;
   // The slowest correct run is the clearing pass after reset plus about 290 requests,
   // each a full first-fit scan at worst, with stalls on both sides, roughly 7 ms;
   // the limit below is a few times that.
   localparam int TIMEOUT_NS    = 20_000_000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [1:0] subpart, [17:2] unit_index, [23:18] zero
   logic [1:0]  req_tuser  = '0;   // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [1:0] status, [17:2] granted_index,
                                   // [18] already_free, [44:19] used_amount
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [18:0] csr_wdata  = '0;

   int          outstanding;
   int          mismatches;

   // Register values for the next setting; written out together, during the clearing pass or while the block idles.
   logic [18:0] csr_image [CSR_COUNT];
   // Bumped by the stimulus to ask the receiver for one long hold-off.
   int unsigned hold_request = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   block_bitmap_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   block_bitmap_allocator_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   // Presents one request beat and returns at the edge that takes it. Valid stays high,
   // so a following call in the same time step simply replaces the payload.
   task automatic offer_request(input logic [1:0] kind, input logic [1:0] sp,
                                input logic [15:0] idx);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, idx, sp};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      if (cycles != 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // The checker's count is registered, hence the edge before the first look.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Every register gets written on each call, one per cycle.
   task automatic load_csr_image();
      for (int i = 0; i < CSR_COUNT; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= csr_image[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Result back-pressure: runs of always ready, mostly ready, mostly stalled and
   // alternating, with one long hold-off on request so that the block backs up.
   initial begin : rsp_backpressure
      int unsigned seen_hold, mode, span;
      seen_hold = 0;
      span = 0;
      mode = 0;
      @(posedge clock);
      forever begin
         if (hold_request != seen_hold) begin
            seen_hold = hold_request;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
         end
         span--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
         @(posedge clock);
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int unsigned roll, burst_left, stream_left, sp_count;
      logic [1:0]  sp;
      logic [15:0] idx;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Four subparts with a full, an empty, a just-over-one-sector and a
      // one-unit count. Registers may be written during the clearing pass after reset;
      // the first request then waits for the pass to end.
      csr_image[CSR_SUBPART_COUNT] = 19'd4;
      csr_image[CSR_UNIT_COUNT_0]  = 19'd65536;
      csr_image[CSR_UNIT_COUNT_1]  = 19'd0;
      csr_image[CSR_UNIT_COUNT_2]  = 19'd4097;
      csr_image[CSR_UNIT_COUNT_3]  = 19'd1;
      csr_image[CSR_RESERVED]      = 19'd0;
      csr_image[CSR_UNIT_SHIFT]    = 19'd0;
      load_csr_image();
      offer_request(REQ_COUNT, 2'd0, 16'd0);       // empty bitmap counts zero
      offer_request(REQ_ALLOC, 2'd0, 16'd0);       // first fit lands on unit 0
      offer_request(REQ_ALLOC, 2'd0, 16'd0);
      offer_request(REQ_ALLOC, 2'd0, 16'hFFFF);    // top unit by name
      offer_request(REQ_ALLOC, 2'd0, 16'hFFFF);    // already taken
      offer_request(REQ_ALLOC, 2'd1, 16'd0);       // zero unit count: nothing to search
      offer_request(REQ_ALLOC, 2'd1, 16'd40000);   // named unit beyond the unit count
      offer_request(REQ_ALLOC, 2'd2, 16'd0);
      offer_request(REQ_ALLOC, 2'd3, 16'd1);
      offer_request(REQ_ALLOC, 2'd3, 16'd0);       // one unit still searches a sector
      offer_request(REQ_ALLOC, 2'd3, 16'd0);
      offer_request(REQ_FREE,  2'd0, 16'd1);
      offer_request(REQ_FREE,  2'd0, 16'd1);       // freeing a clear bit
      offer_request(REQ_ALLOC, 2'd0, 16'd0);       // the freed hole is found again
      offer_request(REQ_FREE,  2'd2, 16'd0);
      offer_request(REQ_UNUSED, 2'd0, 16'd5);
      offer_request(REQ_FREE,  2'd3, 16'hFFFF);
      offer_request(REQ_COUNT, 2'd0, 16'd0);
      wait_for_results();

      // Two subparts in use, the largest shift and a small reserve; the count ignores
      // its subpart and index fields and still covers subparts 2 and 3.
      csr_image[CSR_SUBPART_COUNT] = 19'd2;
      csr_image[CSR_RESERVED]      = 19'd3;
      csr_image[CSR_UNIT_SHIFT]    = 19'd7;
      load_csr_image();
      offer_request(REQ_ALLOC, 2'd2, 16'd5);       // subpart out of use
      offer_request(REQ_FREE,  2'd3, 16'd1);
      offer_request(REQ_COUNT, 2'd3, 16'hFFFF);
      wait_for_results();

      // A reserve above the used count saturates to zero.
      csr_image[CSR_RESERVED] = 19'd262144;
      load_csr_image();
      offer_request(REQ_COUNT, 2'd1, 16'hAAAA);
      wait_for_results();

      // Random part. Each phase picks a new setting while the block is idle; most
      // requests hit subparts in use with small indexes so that allocations collide,
      // frees find set bits and first fit has to walk past taken units.
      burst_left = 0;
      stream_left = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0)
            csr_image[CSR_SUBPART_COUNT] = 19'd1;
         else if (phase == PHASES - 1)
            csr_image[CSR_SUBPART_COUNT] = 19'd4;
         else
            csr_image[CSR_SUBPART_COUNT] = 19'($urandom_range(1, SUBPARTS));
         for (int j = 0; j < SUBPARTS; j++) begin
            case ($urandom_range(0, 6))
               0: csr_image[CSR_UNIT_COUNT_0 + j] = 19'd0;
               1: csr_image[CSR_UNIT_COUNT_0 + j] = 19'd1;
               2: csr_image[CSR_UNIT_COUNT_0 + j] = 19'd4096;
               3: csr_image[CSR_UNIT_COUNT_0 + j] = 19'd4097;
               4: csr_image[CSR_UNIT_COUNT_0 + j] = 19'd65535;
               5: csr_image[CSR_UNIT_COUNT_0 + j] = 19'd65536;
               default: csr_image[CSR_UNIT_COUNT_0 + j] = 19'($urandom_range(0, 65536));
            endcase
         end
         case ($urandom_range(0, 3))
            0: csr_image[CSR_RESERVED] = 19'd0;
            1: csr_image[CSR_RESERVED] = 19'd262144;
            2: csr_image[CSR_RESERVED] = 19'($urandom_range(0, 64));
            default: csr_image[CSR_RESERVED] = 19'($urandom_range(0, 262144));
         endcase
         csr_image[CSR_UNIT_SHIFT] = (phase == 0) ? 19'd7 : 19'($urandom_range(0, 7));
         load_csr_image();
         sp_count = csr_image[CSR_SUBPART_COUNT];

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Once, the receiver holds off for a long stretch while requests keep
            // coming back to back, so the block fills and stops taking requests.
            if (phase == 1 && n == 5) begin
               hold_request <= hold_request + 1;
               stream_left = 16;
            end
            if (stream_left != 0) begin
               stream_left--;
            end else if (burst_left == 0) begin
               pause_sender($urandom_range(0, 6));
               burst_left = $urandom_range(1, 12);
            end else begin
               burst_left--;
            end

            roll = $urandom_range(0, 99);
            sp   = 2'($urandom_range(0, sp_count - 1));
            if (roll < 10) begin
               offer_request(REQ_COUNT, 2'($urandom), 16'($urandom));
            end else if (roll < 40) begin
               offer_request(REQ_ALLOC, sp, 16'd0);
            end else if (roll < 60) begin
               idx = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(1, 255));
               // Index 0 would turn this into a first fit; keep it a named unit.
               if (idx == 0)
                  idx = 16'd1;
               offer_request(REQ_ALLOC, sp, idx);
            end else if (roll < 90) begin
               idx = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 255));
               offer_request(REQ_FREE, sp, idx);
            end else begin
               // Noise: any type, any subpart, any index.
               offer_request(2'($urandom), 2'($urandom), 16'($urandom));
            end
         end
         wait_for_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
